[design/html_entity_subset_decoder_defines.svh]
// ----------------------------------------------------------------------------
// HTML entity subset decoder: assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_SUBSET_DECODER_DEFINES_SVH
`define HTML_ENTITY_SUBSET_DECODER_DEFINES_SVH

// expression holds at every edge
`define HESD_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define HESD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define HESD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/hesd_pkg.sv]
// ----------------------------------------------------------------------------
// HTML entity subset decoder: package
// Item types, match state codes, character constants and held-text lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package hesd_pkg;

	localparam int MaxResults = 6;
	localparam int CntW       = $clog2(MaxResults + 1);

	typedef logic [7:0] byte_t;

	typedef struct packed {
		byte_t in_byte;
		logic  in_end;
	} in_item_t;

	typedef struct packed {
		byte_t out_byte;
		logic  run_last;
		logic  text_done;
	} out_item_t;

	// how much of a candidate entity is held back
	typedef enum logic [3:0] {
		MP_IDLE = 4'd0,
		MP_AMP  = 4'd1,   // "&"
		MP_HASH = 4'd2,   // "&#"
		MP_ONE  = 4'd3,   // "&#1"
		MP_TEN  = 4'd4,   // "&#10"
		MP_Q    = 4'd5,   // "&q"
		MP_QU   = 4'd6,   // "&qu"
		MP_QUO  = 4'd7,   // "&quo"
		MP_QUOT = 4'd8,   // "&quot"
		MP_A    = 4'd9,   // "&a"
		MP_AM   = 4'd10,  // "&am"
		MP_AMPP = 4'd11   // "&amp"
	} match_t;

	// results of one item, first result in the low byte
	typedef struct packed {
		logic [MaxResults-1:0][7:0] bytes;
		logic [CntW-1:0]            count;
		logic                       done;
	} res_list_t;

	localparam byte_t ChrAmp   = 8'h26;
	localparam byte_t ChrHash  = 8'h23;
	localparam byte_t ChrOne   = 8'h31;
	localparam byte_t ChrZero  = 8'h30;
	localparam byte_t ChrSemi  = 8'h3B;
	localparam byte_t ChrLowQ  = 8'h71;
	localparam byte_t ChrLowU  = 8'h75;
	localparam byte_t ChrLowO  = 8'h6F;
	localparam byte_t ChrLowT  = 8'h74;
	localparam byte_t ChrLowA  = 8'h61;
	localparam byte_t ChrLowM  = 8'h6D;
	localparam byte_t ChrLowP  = 8'h70;
	localparam byte_t ChrLf    = 8'h0A;
	localparam byte_t ChrQuote = 8'h22;

	localparam logic [0:7][7:0] TxtLf    = {"&#10;", 24'h0};
	localparam logic [0:7][7:0] TxtQuote = {"&quot", 24'h0};
	localparam logic [0:7][7:0] TxtAmp   = {"&amp;", 24'h0};

	function automatic logic [CntW-1:0] held_len(match_t s);
		logic [CntW-1:0] n;
		case (s)
			MP_AMP:                    n = CntW'(1);
			MP_HASH, MP_Q, MP_A:       n = CntW'(2);
			MP_ONE, MP_QU, MP_AM:      n = CntW'(3);
			MP_TEN, MP_QUO, MP_AMPP:   n = CntW'(4);
			MP_QUOT:                   n = CntW'(5);
			default:                   n = '0;
		endcase
		return n;
	endfunction

	// i-th byte of the text held in state s (all held texts are entity prefixes)
	function automatic byte_t held_char(match_t s, logic [2:0] i);
		byte_t c;
		case (s)
			MP_Q, MP_QU, MP_QUO, MP_QUOT: c = TxtQuote[i];
			MP_A, MP_AM, MP_AMPP:         c = TxtAmp[i];
			default:                      c = TxtLf[i];
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[design/hesd_step.sv]
// ----------------------------------------------------------------------------
// HTML entity subset decoder: step logic
// Advances the match state by one byte and builds the list of result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module hesd_step (
	input  wire hesd_pkg::match_t   state,
	input  wire hesd_pkg::in_item_t item,
	output hesd_pkg::match_t        next_state,
	output hesd_pkg::res_list_t     list
);
	import hesd_pkg::*;

	byte_t           b;
	logic            is_part;
	logic            is_cmp;
	match_t          adv;
	byte_t           ent;
	logic [CntW-1:0] lp;
	logic [CntW-1:0] ls;
	logic            has_m;
	byte_t           m;
	match_t          s2;
	logic [CntW-1:0] slot;
	logic [CntW-1:0] j;

	assign b = item.in_byte;

	always_comb begin
		is_part = 1'b0;
		is_cmp  = 1'b0;
		adv     = MP_IDLE;
		ent     = '0;
		case (state)
			MP_AMP: begin
				if (b == ChrHash) begin
					is_part = 1'b1;
					adv     = MP_HASH;
				end else if (b == ChrLowQ) begin
					is_part = 1'b1;
					adv     = MP_Q;
				end else if (b == ChrLowA) begin
					is_part = 1'b1;
					adv     = MP_A;
				end
			end
			MP_HASH: begin
				is_part = (b == ChrOne);
				adv     = MP_ONE;
			end
			MP_ONE: begin
				is_part = (b == ChrZero);
				adv     = MP_TEN;
			end
			MP_TEN: begin
				is_cmp = (b == ChrSemi);
				ent    = ChrLf;
			end
			MP_Q: begin
				is_part = (b == ChrLowU);
				adv     = MP_QU;
			end
			MP_QU: begin
				is_part = (b == ChrLowO);
				adv     = MP_QUO;
			end
			MP_QUO: begin
				is_part = (b == ChrLowT);
				adv     = MP_QUOT;
			end
			MP_QUOT: begin
				is_cmp = (b == ChrSemi);
				ent    = ChrQuote;
			end
			MP_A: begin
				is_part = (b == ChrLowM);
				adv     = MP_AM;
			end
			MP_AM: begin
				is_part = (b == ChrLowP);
				adv     = MP_AMPP;
			end
			MP_AMPP: begin
				is_cmp = (b == ChrSemi);
				ent    = ChrAmp;
			end
			default: ;
		endcase
	end

	// list = held prefix of old state, then an optional middle byte, then flush of new state
	always_comb begin
		lp    = '0;
		has_m = 1'b0;
		m     = b;
		s2    = MP_IDLE;
		// unused codes have zero held length and so act as idle
		if (held_len(state) != '0) begin
			if (is_cmp) begin
				has_m = 1'b1;
				m     = ent;
			end else if (is_part) begin
				s2 = adv;
			end else begin
				lp = held_len(state);
				if (b == ChrAmp)
					s2 = MP_AMP;
				else
					has_m = 1'b1;
			end
		end else if (b == ChrAmp) begin
			s2 = MP_AMP;
		end else begin
			has_m = 1'b1;
		end

		ls         = item.in_end ? held_len(s2) : '0;
		next_state = item.in_end ? MP_IDLE : s2;

		for (int i = 0; i < MaxResults; i++) begin
			slot = CntW'(i);
			j    = slot - lp - CntW'(has_m);
			if (slot < lp)
				list.bytes[i] = held_char(state, 3'(slot));
			else if (slot == lp && has_m)
				list.bytes[i] = m;
			else
				list.bytes[i] = held_char(s2, 3'(j));
		end
		list.count = lp + CntW'(has_m) + ls;
		list.done  = item.in_end;
	end

endmodule

`default_nettype wire

[design/html_entity_subset_decoder.sv]
// ----------------------------------------------------------------------------
// HTML entity subset decoder
// Replaces "&#10;", "&quot;" and "&amp;" in a byte stream; other bytes pass.
// ----------------------------------------------------------------------------
// Usage:
//   The text channel (text_valid, text_stall, text_item) takes one byte per
//   item; in_end marks the last byte of a text. The char channel (char_valid,
//   char_stall, char_item) delivers decoded bytes, one per item; run_last
//   flags the last byte caused by an input item and text_done the last byte
//   of a text.
//   An input item is decoded in the cycle it is accepted and its results sit
//   in the result buffer on the next cycle.
//   While char_stall is low, a byte that yields one result or none does not
//   hold the input, so plain text runs at one byte per cycle. An item with N
//   results holds the input while the result buffer drains, one byte per
//   cycle unless stalled (N up to 6, only on a broken match or text-end flush).
//   Bytes that may start an entity yield nothing until the match resolves.
//   When char_stall is high the current result holds, and text_stall rises
//   once the buffer cannot take the next item's results.
//   Reset empties the result buffer and clears the match state.
// ----------------------------------------------------------------------------
`default_nettype none

module html_entity_subset_decoder (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      text_valid,
	output logic                     text_stall,
	input  wire hesd_pkg::in_item_t  text_item,
	output logic                     char_valid,
	input  wire                      char_stall,
	output hesd_pkg::out_item_t      char_item
);
	import hesd_pkg::*;

	`include "html_entity_subset_decoder_defines.svh"

	match_t                     match_q;
	match_t                     match_nxt;
	res_list_t                  list;
	logic [MaxResults-1:0][7:0] buf_q;
	logic [CntW-1:0]            len_q;
	logic [CntW-1:0]            pos_q;
	logic                       done_q;
	logic                       last;
	logic                       accept;

	hesd_step u_step (
		.state      (match_q),
		.item       (text_item),
		.next_state (match_nxt),
		.list       (list)
	);

	assign char_valid = (pos_q != len_q);
	assign last       = char_valid && (pos_q == len_q - CntW'(1));
	assign text_stall = char_valid && !(last && !char_stall);
	assign accept     = text_valid && !text_stall;

	assign char_item.out_byte  = buf_q[0];
	assign char_item.run_last  = last;
	assign char_item.text_done = last && done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= MP_IDLE;
			len_q   <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			match_q <= match_nxt;
			len_q   <= list.count;
			pos_q   <= '0;
		end else if (char_valid && !char_stall) begin
			pos_q <= pos_q + CntW'(1);
		end
	end

	// result bytes shift down as they are taken
	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q  <= list.bytes;
			done_q <= list.done;
		end else if (char_valid && !char_stall) begin
			buf_q <= buf_q >> 8;
		end
	end

	`HESD_ASSERT(a_pos_in_range, pos_q <= len_q && len_q <= CntW'(MaxResults), "buffer index out of range")
	`HESD_ASSERT_NEXT(a_end_has_result, accept && text_item.in_end, char_valid, "text end gave no result")
	`HESD_ASSERT_SAME(a_done_idle, char_valid && char_item.text_done, match_q == MP_IDLE, "state held past text end")
	`HESD_ASSERT_NEXT(a_run_continues, char_valid && !char_stall && !last, char_valid, "result run cut short")

endmodule

`default_nettype wire

[tb/tb_html_entity_subset_decoder.sv]
// ----------------------------------------------------------------------------
// HTML entity subset decoder testbench
// A short table of directed text, then random text built around the three
// entities, whole or cut off by a stray byte. Every accepted byte is run
// through a local decoder model, and each output byte is compared against the
// oldest pending expectation. The sender works in bursts and the receiver
// stalls in patterns, with one long hold-off that fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_html_entity_subset_decoder;
	import hesd_pkg::*;

	localparam int RandomItems = 325;
	localparam int StuckLimit  = 2000;
	localparam int HoldOff     = 200;
	localparam int HoldAfter   = 80;

	typedef struct packed {
		in_item_t  item;
		logic      typed;
		out_item_t res;
	} stim_row_t;

	typedef enum logic [1:0] {
		SINK_FREE,
		SINK_LIGHT,
		SINK_HEAVY,
		SINK_TOGGLE
	} sink_mode_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      text_valid = 1'b0;
	logic      text_stall;
	in_item_t  text_item = '0;
	logic      char_valid;
	logic      char_stall;
	out_item_t char_item;

	// directed text; rows with typed set carry their single result
	stim_row_t directed_rows [25] = '{
		'{'{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0}},
		'{'{8'hFF, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b0}},
		'{'{ChrAmp, 1'b0}, 1'b0, '0},
		'{'{ChrHash, 1'b0}, 1'b0, '0},
		'{'{ChrOne, 1'b0}, 1'b0, '0},
		'{'{ChrZero, 1'b0}, 1'b0, '0},
		'{'{ChrSemi, 1'b0}, 1'b1, '{ChrLf, 1'b1, 1'b0}},
		'{'{ChrAmp, 1'b0}, 1'b0, '0},
		'{'{ChrLowQ, 1'b0}, 1'b0, '0},
		'{'{ChrLowU, 1'b0}, 1'b0, '0},
		'{'{ChrLowO, 1'b0}, 1'b0, '0},
		'{'{ChrLowT, 1'b0}, 1'b0, '0},
		'{'{ChrSemi, 1'b0}, 1'b1, '{ChrQuote, 1'b1, 1'b0}},
		'{'{ChrAmp, 1'b0}, 1'b0, '0},
		'{'{ChrLowA, 1'b0}, 1'b0, '0},
		'{'{ChrLowM, 1'b0}, 1'b0, '0},
		'{'{ChrLowP, 1'b0}, 1'b0, '0},
		'{'{ChrSemi, 1'b0}, 1'b1, '{ChrAmp, 1'b1, 1'b0}},
		// "&q" broken by a new '&', which starts "&amp" flushed at end of text
		'{'{ChrAmp, 1'b0}, 1'b0, '0},
		'{'{ChrLowQ, 1'b0}, 1'b0, '0},
		'{'{ChrAmp, 1'b0}, 1'b0, '0},
		'{'{ChrLowA, 1'b0}, 1'b0, '0},
		'{'{ChrLowM, 1'b0}, 1'b0, '0},
		'{'{ChrLowP, 1'b1}, 1'b0, '0},
		'{'{8'h80, 1'b1}, 1'b1, '{8'h80, 1'b1, 1'b1}}
	};

	stim_row_t  text_plan[$];
	out_item_t  expected_chars[$];
	out_item_t  step_results[$];
	byte_t      decoded_bytes[$];
	match_t     prefix_state = MP_IDLE;
	out_item_t  want;

	logic       rst_done = 1'b0;
	logic       text_took = 1'b0;
	int         drv_idx = 0;
	int         acc_idx = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         hold_left = 0;
	logic       held_off = 1'b0;
	int         mode_left = 0;
	sink_mode_t sink_mode = SINK_FREE;
	int         stuck_cycles = 0;
	int         fail_count = 0;

	html_entity_subset_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_item  (text_item),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what, int got, int exp_val);
		fail_count++;
		$display("mismatch %s: got %0h, expected %0h (item %0d)", what, got, exp_val,
			acc_idx);
	endtask

	// append the verbatim text held back in state s
	function automatic void spill_prefix(match_t s);
		string held;
		int    i;
		case (s)
			MP_AMP:  held = "&";
			MP_HASH: held = "&#";
			MP_ONE:  held = "&#1";
			MP_TEN:  held = "&#10";
			MP_Q:    held = "&q";
			MP_QU:   held = "&qu";
			MP_QUO:  held = "&quo";
			MP_QUOT: held = "&quot";
			MP_A:    held = "&a";
			MP_AM:   held = "&am";
			MP_AMPP: held = "&amp";
			default: held = "";
		endcase
		for (i = 0; i < held.len(); i++)
			decoded_bytes.push_back(held[i]);
	endfunction

	// decode one input byte into step_results and advance prefix_state
	function automatic void decode_char(in_item_t it);
		match_t    s;
		match_t    nxt;
		logic      hit;
		byte_t     hit_char;
		byte_t     b;
		out_item_t r;
		int        i;
		s = prefix_state;
		b = it.in_byte;
		nxt = MP_IDLE;
		hit = 1'b0;
		hit_char = '0;
		decoded_bytes.delete();
		step_results.delete();
		if (s != MP_IDLE) begin
			case (s)
				MP_AMP: begin
					if (b == ChrHash)
						nxt = MP_HASH;
					else if (b == ChrLowQ)
						nxt = MP_Q;
					else if (b == ChrLowA)
						nxt = MP_A;
				end
				MP_HASH: if (b == ChrOne) nxt = MP_ONE;
				MP_ONE:  if (b == ChrZero) nxt = MP_TEN;
				MP_TEN: begin
					hit = (b == ChrSemi);
					hit_char = ChrLf;
				end
				MP_Q:    if (b == ChrLowU) nxt = MP_QU;
				MP_QU:   if (b == ChrLowO) nxt = MP_QUO;
				MP_QUO:  if (b == ChrLowT) nxt = MP_QUOT;
				MP_QUOT: begin
					hit = (b == ChrSemi);
					hit_char = ChrQuote;
				end
				MP_A:    if (b == ChrLowM) nxt = MP_AM;
				MP_AM:   if (b == ChrLowP) nxt = MP_AMPP;
				MP_AMPP: begin
					hit = (b == ChrSemi);
					hit_char = ChrAmp;
				end
				default: ;
			endcase
			if (hit) begin
				decoded_bytes.push_back(hit_char);
				s = MP_IDLE;
			end else if (nxt != MP_IDLE) begin
				s = nxt;
			end else begin
				// broken match: held text goes out, the byte starts over
				spill_prefix(s);
				s = MP_IDLE;
				if (b == ChrAmp)
					s = MP_AMP;
				else
					decoded_bytes.push_back(b);
			end
		end else if (b == ChrAmp) begin
			s = MP_AMP;
		end else begin
			decoded_bytes.push_back(b);
		end
		if (it.in_end) begin
			spill_prefix(s);
			s = MP_IDLE;
		end
		prefix_state = s;
		for (i = 0; i < decoded_bytes.size(); i++) begin
			r.out_byte = decoded_bytes[i];
			r.run_last = (i == decoded_bytes.size() - 1);
			r.text_done = r.run_last && it.in_end;
			step_results.push_back(r);
		end
	endfunction

	// sender: bursts of items with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (rst_done && (!text_valid || text_took)) begin
			if (drv_idx < text_plan.size() && gap_left == 0) begin
				text_valid <= 1'b1;
				text_item <= text_plan[drv_idx].item;
				drv_idx++;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				text_valid <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end
		end
	end

	// receiver: stall patterns picked at random, with one long hold-off
	initial begin
		char_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && acc_idx >= HoldAfter) begin
				held_off = 1'b1;
				hold_left = HoldOff;
			end
			if (hold_left > 0) begin
				char_stall <= 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					sink_mode = sink_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 64);
				end
				mode_left--;
				case (sink_mode)
					SINK_FREE:  char_stall <= 1'b0;
					SINK_LIGHT: char_stall <= ($urandom_range(0, 3) == 0);
					SINK_HEAVY: char_stall <= ($urandom_range(0, 3) != 0);
					default:    char_stall <= ~char_stall;
				endcase
			end
		end
	end

	// predict on accepted input, check accepted output
	always @(posedge clk) begin
		if (rst_done) begin
			text_took = text_valid && !text_stall;
			if (text_took) begin
				decode_char(text_item);
				if (text_plan[acc_idx].typed)
					expected_chars.push_back(text_plan[acc_idx].res);
				else
					foreach (step_results[i])
						expected_chars.push_back(step_results[i]);
				acc_idx++;
			end
			if (char_valid && !char_stall) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("unexpected out_byte", char_item.out_byte, 0);
				end else begin
					want = expected_chars.pop_front();
					if (char_item.out_byte != want.out_byte)
						report_mismatch("out_byte", char_item.out_byte, want.out_byte);
					if (char_item.run_last != want.run_last)
						report_mismatch("run_last", char_item.run_last, want.run_last);
					if (char_item.text_done != want.text_done)
						report_mismatch("text_done", char_item.text_done, want.text_done);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (rst_done) begin
			if ((text_valid && !text_stall) || (char_valid && !char_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		if (stuck_cycles >= StuckLimit) begin
			$display("timeout: no item moved for %0d cycles", StuckLimit);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int        kind;
		int        cut;
		int        n;
		int        i;
		string     ent;
		byte_t     chunk[$];
		stim_row_t row;

		arst_n = 1'b0;

		foreach (directed_rows[k])
			text_plan.push_back(directed_rows[k]);

		// random text: whole entities, cut-off entities, plain bytes
		while (text_plan.size() < $size(directed_rows) + RandomItems) begin
			kind = $urandom_range(0, 9);
			chunk.delete();
			if (kind < 7) begin
				case ($urandom_range(0, 2))
					0:       ent = "&#10;";
					1:       ent = "&quot;";
					default: ent = "&amp;";
				endcase
				cut = (kind < 4) ? ent.len() : $urandom_range(1, ent.len() - 1);
				for (i = 0; i < cut; i++)
					chunk.push_back(ent[i]);
				if (kind >= 4) begin
					case ($urandom_range(0, 3))
						0:       chunk.push_back(ChrAmp);
						1:       chunk.push_back(ChrSemi);
						default: chunk.push_back(byte_t'($urandom_range(0, 255)));
					endcase
				end
			end else begin
				n = $urandom_range(1, 4);
				repeat (n) chunk.push_back(byte_t'($urandom_range(0, 255)));
			end
			foreach (chunk[j]) begin
				row = '0;
				row.item.in_byte = chunk[j];
				row.item.in_end = ($urandom_range(0, 15) == 0);
				text_plan.push_back(row);
			end
		end
		// close the last text so nothing stays held
		text_plan[text_plan.size() - 1].item.in_end = 1'b1;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		rst_done <= 1'b1;

		while (acc_idx < text_plan.size() || expected_chars.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
